// File: rtl/core/mah_pkg.sv
// ----------------------------------------------------------------------------
// mah_pkg: shared definitions for the magnetometer average and heading block
// Window size, datapath widths, axis codes, CORDIC arc table and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package mah_pkg;

  // averaging window and derived widths
  localparam int WINDOW     = 8;
  localparam int NUM_AXES   = 3;
  localparam int COUNT_W    = 13;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = COUNT_W + $clog2(WINDOW);
  localparam int MEAN_SHIFT = 6;
  localparam int NUM_W      = SUM_W + MEAN_SHIFT;
  localparam int MEAN_W     = 19;
  localparam int HEAD_W     = 16;

  // reciprocal of the window, scaled by 2^NUM_W
  localparam logic [NUM_W-1:0] RECIP = NUM_W'((2 ** NUM_W) / WINDOW);
  localparam logic [NUM_W-1:0] WIN_N = NUM_W'(WINDOW);
  localparam logic [NUM_W-1:0] WIN_HALF = NUM_W'(WINDOW / 2);

  // axis codes
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // cordic geometry
  localparam int CORDIC_STEPS = 20;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int OPND_SHIFT   = 20;
  localparam int XY_W         = 42;
  localparam int Z_W          = 27;
  localparam int ANG_FRAC     = 10;
  localparam logic signed [Z_W-1:0] HALF_TURN  = Z_W'(18432000);
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(512);
  localparam logic signed [Z_W-1:0] HEAD_MAX   = Z_W'(18000);

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              num;
    logic              mul;
    logic              fix;
    logic [AXIS_W-1:0] axis;
    logic              init;
    logic              step;
    logic [ITER_W-1:0] iter;
    logic              out_load;
  } mah_cmd_t;

  // sign extend one axis count to the running sum width
  function automatic logic signed [SUM_W-1:0] count_ext(input logic signed [COUNT_W-1:0] c);
    return {{(SUM_W-COUNT_W){c[COUNT_W-1]}}, c};
  endfunction

  // atan(2^-i) in 1/1024 centidegree
  function automatic logic signed [Z_W-1:0] arc_of(input logic [ITER_W-1:0] idx);
    logic signed [Z_W-1:0] a;
    unique case (idx)
      5'd0:    a = Z_W'(4608000);
      5'd1:    a = Z_W'(2720261);
      5'd2:    a = Z_W'(1437311);
      5'd3:    a = Z_W'(729602);
      5'd4:    a = Z_W'(366217);
      5'd5:    a = Z_W'(183287);
      5'd6:    a = Z_W'(91666);
      5'd7:    a = Z_W'(45836);
      5'd8:    a = Z_W'(22918);
      5'd9:    a = Z_W'(11459);
      5'd10:   a = Z_W'(5730);
      5'd11:   a = Z_W'(2865);
      5'd12:   a = Z_W'(1432);
      5'd13:   a = Z_W'(716);
      5'd14:   a = Z_W'(358);
      5'd15:   a = Z_W'(179);
      5'd16:   a = Z_W'(90);
      5'd17:   a = Z_W'(45);
      5'd18:   a = Z_W'(22);
      5'd19:   a = Z_W'(11);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/magnetometer_average_heading_top.sv
// ----------------------------------------------------------------------------
// magnetometer_average_heading_top: window average and heading of samples
// Converts raw register bytes to 13-bit counts, averages them over a ring of
// WINDOW slots and returns the means with the atan2 heading in centidegrees.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    x/y/z low and high bytes
//   out      out_valid / out_ready  mean_x, mean_y, mean_z, heading_centideg
//
// Samples are taken one at a time: a load step, a numerator step, a multiply
// and a correction step per axis on the shared reciprocal multiplier, a CORDIC
// setup step, 20 CORDIC iterations and a load into the output register.
// Reset clears the sample rings, running sums and write slot.
// A result waiting in the output register does not stop a new beat from
// being accepted; only the final hand-off waits for out_ready.
// ----------------------------------------------------------------------------
module magnetometer_average_heading_top import mah_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_x_low_byte,
  input  logic [7:0]               in_x_high_byte,
  input  logic [7:0]               in_y_low_byte,
  input  logic [7:0]               in_y_high_byte,
  input  logic [7:0]               in_z_low_byte,
  input  logic [7:0]               in_z_high_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MEAN_W-1:0] out_mean_x,
  output logic signed [MEAN_W-1:0] out_mean_y,
  output logic signed [MEAN_W-1:0] out_mean_z,
  output logic signed [HEAD_W-1:0] out_heading_centideg
);

  mah_cmd_t cmd;

  // sequencer
  mah_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and storage
  mah_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_x_low_byte        (in_x_low_byte),
    .in_x_high_byte       (in_x_high_byte),
    .in_y_low_byte        (in_y_low_byte),
    .in_y_high_byte       (in_y_high_byte),
    .in_z_low_byte        (in_z_low_byte),
    .in_z_high_byte       (in_z_high_byte),
    .out_mean_x           (out_mean_x),
    .out_mean_y           (out_mean_y),
    .out_mean_z           (out_mean_z),
    .out_heading_centideg (out_heading_centideg)
  );

endmodule

// File: rtl/core/mah_ctrl.sv
// ----------------------------------------------------------------------------
// mah_ctrl: sequencer for the magnetometer average and heading block
// Walks each sample through load, window division per axis, the CORDIC
// iterations and the hand-off into the output register.
// ----------------------------------------------------------------------------
module mah_ctrl import mah_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output mah_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NUM  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;
  localparam logic [2:0] S_ITER = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    iter_nxt     = iter_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.axis     = axis_r;
    cmd.iter     = iter_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        cmd.num   = 1'b1;
        axis_nxt  = AXIS_X;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_INIT;
        end else begin
          axis_nxt  = axis_r + AXIS_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          iter_nxt = iter_r + ITER_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_X;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_NUM))
    else $error("accepted beat did not start processing");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while result pending");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER) |-> (iter_r < ITER_W'(CORDIC_STEPS)))
    else $error("cordic iteration count out of range");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> ((state_r == S_IDLE) && !out_valid_r))
    else $error("controller not idle after reset");
`endif

endmodule

// File: rtl/core/mah_dpath.sv
// ----------------------------------------------------------------------------
// mah_dpath: datapath for the magnetometer average and heading block
// Sample rings with running sums, shared reciprocal multiplier for the window
// average, iterative CORDIC for the heading and the output register.
// ----------------------------------------------------------------------------
module mah_dpath import mah_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mah_cmd_t                 cmd,
  input  logic [7:0]               in_x_low_byte,
  input  logic [7:0]               in_x_high_byte,
  input  logic [7:0]               in_y_low_byte,
  input  logic [7:0]               in_y_high_byte,
  input  logic [7:0]               in_z_low_byte,
  input  logic [7:0]               in_z_high_byte,
  output logic signed [MEAN_W-1:0] out_mean_x,
  output logic signed [MEAN_W-1:0] out_mean_y,
  output logic signed [MEAN_W-1:0] out_mean_z,
  output logic signed [HEAD_W-1:0] out_heading_centideg
);

  logic signed [COUNT_W-1:0] ring_r [NUM_AXES][WINDOW];
  logic signed [SUM_W-1:0]   sum_r  [NUM_AXES];
  logic signed [SUM_W-1:0]   sum_nxt [NUM_AXES];
  logic signed [COUNT_W-1:0] cnt    [NUM_AXES];
  logic [SLOT_W-1:0]         slot_r, slot_nxt;

  logic [SUM_W-1:0]          mag     [NUM_AXES];
  logic [NUM_W-1:0]          num_nxt [NUM_AXES];
  logic [NUM_W-1:0]          num_r   [NUM_AXES];
  logic                      neg_r   [NUM_AXES];
  logic [2*NUM_W-1:0]        prod_r;
  logic [NUM_W-1:0]          q0, rem, quo;
  logic [MEAN_W-1:0]         quo_m;
  logic signed [MEAN_W-1:0]  mean_nxt;
  logic signed [MEAN_W-1:0]  mean_r  [NUM_AXES];

  logic signed [MEAN_W-1:0]  mx, my;
  logic signed [XY_W-1:0]    xe, ye, x_init, y_init;
  logic signed [Z_W-1:0]     z_init;
  logic signed [XY_W-1:0]    x_r, y_r, xs, ys, x_step, y_step;
  logic signed [Z_W-1:0]     z_r, z_step, arc;
  logic                      zero_r;

  logic signed [Z_W-1:0]     z_abs, z_rnd_mag, z_rnd, z_clamp;
  logic signed [HEAD_W-1:0]  heading_nxt;

  logic signed [MEAN_W-1:0]  out_mean_x_r, out_mean_y_r, out_mean_z_r;
  logic signed [HEAD_W-1:0]  out_heading_r;

  // axis counts and running window sums
  always_comb begin
    cnt[AXIS_X] = {in_x_high_byte, in_x_low_byte[7:3]};
    cnt[AXIS_Y] = {in_y_high_byte, in_y_low_byte[7:3]};
    cnt[AXIS_Z] = {in_z_high_byte, in_z_low_byte[7:3]};
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_nxt[a] = sum_r[a] - count_ext(ring_r[a][slot_r]) + count_ext(cnt[a]);
    end
    if (slot_r == SLOT_W'(WINDOW - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  // ring slots, sums and write slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int s = 0; s < WINDOW; s++) begin
          ring_r[a][s] <= '0;
        end
        sum_r[a] <= '0;
      end
      slot_r <= '0;
    end else if (cmd.load) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ring_r[a][slot_r] <= cnt[a];
        sum_r[a]          <= sum_nxt[a];
      end
      slot_r <= slot_nxt;
    end
  end

  // rounded magnitude numerator: |sum| * 64 + window / 2
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mag[a]     = sum_r[a][SUM_W-1] ? ((~sum_r[a]) + SUM_W'(1)) : sum_r[a];
      num_nxt[a] = {mag[a], {MEAN_SHIFT{1'b0}}} + WIN_HALF;
    end
  end

  // quotient estimate corrected by one compare
  always_comb begin
    q0    = prod_r[2*NUM_W-1 -: NUM_W];
    rem   = num_r[cmd.axis] - q0 * WIN_N;
    quo   = (rem >= WIN_N) ? (q0 + NUM_W'(1)) : q0;
    quo_m = quo[MEAN_W-1:0];
    mean_nxt = neg_r[cmd.axis] ? -$signed(quo_m) : $signed(quo_m);
  end

  // window average registers
  always_ff @(posedge clk) begin
    if (cmd.num) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        num_r[a] <= num_nxt[a];
        neg_r[a] <= sum_r[a][SUM_W-1];
      end
    end
    if (cmd.mul) begin
      prod_r <= {{NUM_W{1'b0}}, num_r[cmd.axis]} * {{NUM_W{1'b0}}, RECIP};
    end
    if (cmd.fix) begin
      mean_r[cmd.axis] <= mean_nxt;
    end
  end

  // cordic start: fold left half plane onto the right
  always_comb begin
    mx = mean_r[AXIS_X];
    my = mean_r[AXIS_Y];
    xe = {{(XY_W-MEAN_W-OPND_SHIFT){mx[MEAN_W-1]}}, mx, {OPND_SHIFT{1'b0}}};
    ye = {{(XY_W-MEAN_W-OPND_SHIFT){my[MEAN_W-1]}}, my, {OPND_SHIFT{1'b0}}};
    if (mx[MEAN_W-1]) begin
      x_init = -xe;
      y_init = -ye;
      z_init = my[MEAN_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      x_init = xe;
      y_init = ye;
      z_init = '0;
    end
  end

  // one vectoring micro-rotation
  always_comb begin
    xs  = x_r >>> cmd.iter;
    ys  = y_r >>> cmd.iter;
    arc = arc_of(cmd.iter);
    if (!y_r[XY_W-1] && (y_r != '0)) begin
      x_step = x_r + ys;
      y_step = y_r - xs;
      z_step = z_r + arc;
    end else begin
      x_step = x_r - ys;
      y_step = y_r + xs;
      z_step = z_r - arc;
    end
  end

  // cordic registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x_r    <= x_init;
      y_r    <= y_init;
      z_r    <= z_init;
      zero_r <= (mx == '0) && (my == '0);
    end else if (cmd.step) begin
      x_r <= x_step;
      y_r <= y_step;
      z_r <= z_step;
    end
  end

  // angle to centidegrees, ties away from zero, then clamp
  always_comb begin
    z_abs     = z_r[Z_W-1] ? -z_r : z_r;
    z_rnd_mag = (z_abs + ROUND_HALF) >>> ANG_FRAC;
    z_rnd     = z_r[Z_W-1] ? -z_rnd_mag : z_rnd_mag;
    if (z_rnd > HEAD_MAX) begin
      z_clamp = HEAD_MAX;
    end else if (z_rnd < -HEAD_MAX) begin
      z_clamp = -HEAD_MAX;
    end else begin
      z_clamp = z_rnd;
    end
    heading_nxt = zero_r ? '0 : z_clamp[HEAD_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mean_x_r  <= mean_r[AXIS_X];
      out_mean_y_r  <= mean_r[AXIS_Y];
      out_mean_z_r  <= mean_r[AXIS_Z];
      out_heading_r <= heading_nxt;
    end
  end

  assign out_mean_x           = out_mean_x_r;
  assign out_mean_y           = out_mean_y_r;
  assign out_mean_z           = out_mean_z_r;
  assign out_heading_centideg = out_heading_r;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for magnetometer_average_heading_top
// Sends raw register samples through the valid/ready input, predicts the
// window means and the CORDIC heading of every sample, and compares each
// beat on the result side with the oldest prediction. Both sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import mah_pkg::*;

  localparam int TOTAL_SAMPLES = 1150;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int MAX_WAIT      = 12;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_PRINTS    = 40;

  localparam longint HALF_TURN_ANG = 18432000;
  localparam longint HEADING_LIMIT = 18000;
  localparam longint ARC_STEP [CORDIC_STEPS] = '{
    4608000, 2720261, 1437311, 729602, 366217, 183287, 91666, 45836,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11
  };

  // raw register bytes of one sample, {high, low} per axis
  typedef struct packed {
    logic [7:0] x_hi;
    logic [7:0] x_lo;
    logic [7:0] y_hi;
    logic [7:0] y_lo;
    logic [7:0] z_hi;
    logic [7:0] z_lo;
  } sample_t;

  typedef struct {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic signed [MEAN_W-1:0] mean_z;
    logic signed [HEAD_W-1:0] heading;
  } means_t;

  typedef enum int {MIX_RANDOM, MIX_SMALL, MIX_ON_AXIS, MIX_EXTREME} sample_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  sample_t                  drv_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [MEAN_W-1:0] out_mean_x;
  logic signed [MEAN_W-1:0] out_mean_y;
  logic signed [MEAN_W-1:0] out_mean_z;
  logic signed [HEAD_W-1:0] out_heading_centideg;

  // predictor state
  logic signed [COUNT_W-1:0] axis_hist [NUM_AXES][WINDOW];
  int unsigned               hist_slot = 0;

  sample_t pending_samples [$];
  means_t  due_results [$];

  int  samples_taken = 0;
  int  results_seen  = 0;
  int  errors        = 0;
  int  cycles        = 0;
  int  src_wait      = 0;
  bit  src_calm      = 1'b0;
  int  snk_wait      = 0;
  int  snk_next;
  bit  snk_calm      = 1'b0;
  bit  sink_hold     = 1'b0;
  bit  hold_done     = 1'b0;
  int  hold_left     = 0;
  means_t want;

  magnetometer_average_heading_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_x_low_byte        (drv_sample.x_lo),
    .in_x_high_byte       (drv_sample.x_hi),
    .in_y_low_byte        (drv_sample.y_lo),
    .in_y_high_byte       (drv_sample.y_hi),
    .in_z_low_byte        (drv_sample.z_lo),
    .in_z_high_byte       (drv_sample.z_hi),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_mean_x           (out_mean_x),
    .out_mean_y           (out_mean_y),
    .out_mean_z           (out_mean_z),
    .out_heading_centideg (out_heading_centideg)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // rounded division, ties away from zero
  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // window average of one axis in 1/64 count
  function automatic longint window_mean(input int axis);
    longint sum;
    sum = 0;
    for (int i = 0; i < WINDOW; i++) sum += axis_hist[axis][i];
    return round_div(sum * 64, WINDOW);
  endfunction

  // vectoring cordic, angle kept in 1/1024 centidegree
  function automatic longint heading_of_means(input longint mx, input longint my);
    longint ax, ay, acc, nx;
    if (mx == 0 && my == 0) return 0;
    ax  = mx * 1048576;
    ay  = my * 1048576;
    acc = 0;
    // left half plane: rotate by a half turn first
    if (ax < 0) begin
      ax  = -ax;
      ay  = -ay;
      acc = (my >= 0) ? HALF_TURN_ANG : -HALF_TURN_ANG;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (ay > 0) begin
        nx  = ax + (ay >>> i);
        ay  = ay - (ax >>> i);
        acc = acc + ARC_STEP[i];
      end else begin
        nx  = ax - (ay >>> i);
        ay  = ay + (ax >>> i);
        acc = acc - ARC_STEP[i];
      end
      ax = nx;
    end
    acc = round_div(acc, 1024);
    if (acc > HEADING_LIMIT) acc = HEADING_LIMIT;
    if (acc < -HEADING_LIMIT) acc = -HEADING_LIMIT;
    return acc;
  endfunction

  // store one accepted sample and queue the means and heading it yields
  task automatic absorb_sample(input sample_t s);
    means_t m;
    longint mx, my, mz, hd;
    axis_hist[0][hist_slot] = {s.x_hi, s.x_lo[7:3]};
    axis_hist[1][hist_slot] = {s.y_hi, s.y_lo[7:3]};
    axis_hist[2][hist_slot] = {s.z_hi, s.z_lo[7:3]};
    hist_slot = (hist_slot + 1 >= WINDOW) ? 0 : hist_slot + 1;
    mx = window_mean(0);
    my = window_mean(1);
    mz = window_mean(2);
    hd = heading_of_means(mx, my);
    m.mean_x  = mx[MEAN_W-1:0];
    m.mean_y  = my[MEAN_W-1:0];
    m.mean_z  = mz[MEAN_W-1:0];
    m.heading = hd[HEAD_W-1:0];
    due_results.push_back(m);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    if (errors < MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, exp_v);
    errors++;
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // {high, low} bytes of one axis
  function automatic logic [15:0] axis_bytes(input sample_mix_t mix);
    logic [7:0] hi, lo;
    lo = 8'($urandom_range(0, 255));
    unique case (mix)
      MIX_SMALL:   hi = 8'($urandom_range(0, 3)) - 8'd2;
      MIX_ON_AXIS: begin
        hi = 8'h00;
        lo = 8'($urandom_range(0, 7));
      end
      MIX_EXTREME: begin
        hi = $urandom_range(0, 1) ? 8'h7F : 8'h80;
        lo = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default:     hi = 8'($urandom_range(0, 255));
    endcase
    return {hi, lo};
  endfunction

  task automatic add_sample(input logic [15:0] xw, input logic [15:0] yw,
                            input logic [15:0] zw);
    pending_samples.push_back({xw, yw, zw});
  endtask

  // driver: one beat at a time, random gap after each acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      src_wait  <= 0;
      hist_slot = 0;
      for (int a = 0; a < NUM_AXES; a++)
        for (int i = 0; i < WINDOW; i++) axis_hist[a][i] = '0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_sample(drv_sample);
        samples_taken <= samples_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (src_wait > 0) begin
          in_valid <= 1'b0;
          src_wait <= src_wait - 1;
        end else if (pending_samples.size() > 0) begin
          drv_sample <= pending_samples.pop_front();
          in_valid   <= 1'b1;
          src_wait   <= draw_wait(src_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 39) == 0) src_calm <= !src_calm;
    end
  end

  // monitor: check each result beat, then stall the next one at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      snk_wait  <= 0;
    end else begin
      snk_next = snk_wait;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          want = due_results.pop_front();
          if (out_mean_x !== want.mean_x) report_mismatch("mean_x", out_mean_x, want.mean_x);
          if (out_mean_y !== want.mean_y) report_mismatch("mean_y", out_mean_y, want.mean_y);
          if (out_mean_z !== want.mean_z) report_mismatch("mean_z", out_mean_z, want.mean_z);
          if (out_heading_centideg !== want.heading)
            report_mismatch("heading_centideg", out_heading_centideg, want.heading);
        end
        snk_next = draw_wait(snk_calm);
      end else if (out_valid && snk_next > 0) begin
        snk_next = snk_next - 1;
      end
      snk_wait  <= snk_next;
      out_ready <= (snk_next == 0) && !sink_hold;
      if ($urandom_range(0, 39) == 0) snk_calm <= !snk_calm;
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      sink_hold <= (hold_left > 1);
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      sink_hold <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [15:0] axis_word [NUM_AXES];
    sample_mix_t burst_mix, fill_mix;
    int          burst_len, flat_axis;
    int          total;

    // directed: origin, negative x axis, extremes, ignored low bits
    add_sample(16'h0000, 16'h0000, 16'h0000);
    add_sample(16'hFFF8, 16'h0000, 16'h0000);
    add_sample(16'h7FFF, 16'h7FFF, 16'h8000);
    add_sample(16'h8000, 16'h7FFF, 16'h7FFF);
    add_sample(16'h0007, 16'h0007, 16'h0007);
    add_sample(16'h00F8, 16'hFF08, 16'h0100);
    add_sample(16'hFFFF, 16'h00FF, 16'h80F8);
    // full window at the negative extreme on x, y exactly zero
    repeat (WINDOW) add_sample(16'h8000, 16'h0003, 16'h7FFF);
    // full window at the positive extreme on x and y, negative extreme on z
    repeat (WINDOW) add_sample(16'h7FFF, 16'h7FFF, 16'h8000);
    add_sample(16'h0000, 16'h8000, 16'h0000);
    add_sample(16'h0000, 16'h7FFF, 16'h0000);
    add_sample(16'h8000, 16'h8000, 16'h7FFF);

    // random bursts of one flavor, from one sample up to twice the window long
    while (pending_samples.size() < TOTAL_SAMPLES) begin
      burst_mix = sample_mix_t'($urandom_range(0, 3));
      burst_len = $urandom_range(1, 2 * WINDOW);
      flat_axis = $urandom_range(0, 1);
      repeat (burst_len) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if (burst_mix == MIX_ON_AXIS && a == flat_axis) begin
            fill_mix = MIX_ON_AXIS;
          end else if (burst_mix == MIX_ON_AXIS) begin
            fill_mix = $urandom_range(0, 1) ? MIX_SMALL : MIX_RANDOM;
          end else begin
            fill_mix = burst_mix;
          end
          axis_word[a] = axis_bytes(fill_mix);
        end
        add_sample(axis_word[0], axis_word[1], axis_word[2]);
      end
    end
    total = pending_samples.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (samples_taken == total && due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
